// ===== src/bagc_pkg.sv =====
package bagc_pkg;

   localparam int BLOCK_LEN = 64;
   localparam int BLK_AW = $clog2(BLOCK_LEN);
   localparam int CNT_W = $clog2(BLOCK_LEN + 1);

   localparam int SMP_W = 24;
   localparam int LVL_W = 23;
   localparam int HP_W = 34;
   localparam int GAIN_W = 51;
   localparam int GCH = 17;
   localparam int GNCH = GAIN_W / GCH;
   localparam int MACC_W = HP_W + GAIN_W;

   localparam logic [2:0] CSR_HPF = 3'd0;
   localparam logic [2:0] CSR_ATTACK = 3'd1;
   localparam logic [2:0] CSR_RELEASE = 3'd2;
   localparam logic [2:0] CSR_THRESHOLD = 3'd3;
   localparam logic [2:0] CSR_SLOPE = 3'd4;
   localparam logic [2:0] CSR_MAKEUP = 3'd5;
   localparam logic [2:0] CSR_LIMIT = 3'd6;

   localparam logic [15:0] HPF_RST = 16'd64750;
   localparam logic [15:0] ATTACK_RST = 16'd58982;
   localparam logic [15:0] RELEASE_RST = 16'd983;
   localparam logic [15:0] THRESHOLD_RST = 16'hCE00;
   localparam logic [15:0] SLOPE_RST = 16'd52429;
   localparam logic [13:0] MAKEUP_RST = 14'd10496;
   localparam logic [22:0] LIMIT_RST = 23'd8300000;

   localparam logic signed [16:0] SILENT_DB = -17'sd25600;
   localparam logic [18:0] DB_PER_OCT = 19'd394566;
   localparam logic [13:0] OCT_PER_DB = 14'd10885;
   localparam logic [15:0] OUT_W_OLD = 16'd58982;
   localparam logic [12:0] OUT_W_NEW = 13'd6554;
   localparam logic [15:0] PEAK_DECAY = 16'd65470;
   localparam logic [30:0] ONE_Q30 = 31'h40000000;

   typedef struct packed {
      logic [15:0] att_coeff;
      logic [15:0] rel_coeff;
      logic [15:0] threshold;
      logic [15:0] slope;
      logic [13:0] makeup;
   } gain_cfg_type;

   function automatic logic [30:0] root_q30(input logic [3:0] k);
      logic [30:0] r;
      case (k)
         4'd0: r = 31'd1518500250;
         4'd1: r = 31'd1276901417;
         4'd2: r = 31'd1170923762;
         4'd3: r = 31'd1121280435;
         4'd4: r = 31'd1097253708;
         4'd5: r = 31'd1085434106;
         4'd6: r = 31'd1079572136;
         4'd7: r = 31'd1076653033;
         4'd8: r = 31'd1075196443;
         4'd9: r = 31'd1074468888;
         4'd10: r = 31'd1074105294;
         4'd11: r = 31'd1073923544;
         4'd12: r = 31'd1073832680;
         4'd13: r = 31'd1073787251;
         4'd14: r = 31'd1073764537;
         4'd15: r = 31'd1073753181;
         default: r = ONE_Q30;
      endcase
      return r;
   endfunction

endpackage

// ===== src/bagc_gain.sv =====
module bagc_gain (
   input  logic                         clock,
   input  logic                         reset,
   input  bagc_pkg::gain_cfg_type       cfg,
   input  logic                         start,
   input  logic [23:0]                  peak,
   output logic                         done,
   output logic [bagc_pkg::GAIN_W-1:0]  gain
);

   localparam logic [3:0] G_IDLE = 4'd0;
   localparam logic [3:0] G_ENV = 4'd1;
   localparam logic [3:0] G_ENVU = 4'd2;
   localparam logic [3:0] G_NORM = 4'd3;
   localparam logic [3:0] G_LOG = 4'd4;
   localparam logic [3:0] G_DB = 4'd5;
   localparam logic [3:0] G_SL = 4'd6;
   localparam logic [3:0] G_G = 4'd7;
   localparam logic [3:0] G_G2 = 4'd8;
   localparam logic [3:0] G_EXP = 4'd9;
   localparam logic [3:0] G_SH = 4'd10;

   logic [3:0] state_ff, state_in;
   logic [31:0] env_ff, env_in;
   logic [23:0] peak_ff, peak_in;
   logic up_ff, up_in;
   logic [47:0] prod_ff, prod_in;
   logic [31:0] norm_ff, norm_in;
   logic [4:0] lz_ff, lz_in;
   logic [3:0] step_ff, step_in;
   logic [30:0] x_ff, x_in;
   logic [15:0] frac_ff, frac_in;
   logic zero_ff, zero_in;
   logic gt_ff, gt_in;
   logic neg_ff, neg_in;
   logic signed [7:0] ip_ff, ip_in;
   logic [15:0] f_ff, f_in;
   logic [30:0] acc_ff, acc_in;
   logic [bagc_pkg::GAIN_W-1:0] gain_ff, gain_in;
   logic done_ff, done_in;

   logic [31:0] tgt, dlt, norm_nxt;
   logic [15:0] coef;
   logic [5:0] amt;
   logic [61:0] sq, eprod;
   logic [31:0] t;
   logic [20:0] full, aval;
   logic signed [16:0] db, thr;
   logic signed [17:0] dif;
   logic [16:0] red, gmag;
   logic signed [17:0] g;
   logic [22:0] q;
   logic signed [23:0] g2;
   logic signed [7:0] sh, nsh;

   always_comb begin
      state_in = state_ff;
      env_in = env_ff;
      peak_in = peak_ff;
      up_in = up_ff;
      prod_in = prod_ff;
      norm_in = norm_ff;
      lz_in = lz_ff;
      step_in = step_ff;
      x_in = x_ff;
      frac_in = frac_ff;
      zero_in = zero_ff;
      gt_in = gt_ff;
      neg_in = neg_ff;
      ip_in = ip_ff;
      f_in = f_ff;
      acc_in = acc_ff;
      gain_in = gain_ff;
      done_in = 1'b0;
      tgt = {peak_ff, 8'd0};
      dlt = '0;
      coef = '0;
      amt = 6'(6'd16 >> step_ff[2:0]);
      norm_nxt = norm_ff;
      sq = 62'(x_ff) * 62'(x_ff);
      t = sq[61:30];
      eprod = 62'(acc_ff) * 62'(bagc_pkg::root_q30(step_ff));
      full = {lz_ff, 16'd0};
      aval = (full > {5'd0, frac_ff}) ? full - {5'd0, frac_ff} : '0;
      db = zero_ff ? bagc_pkg::SILENT_DB : -$signed({1'b0, prod_ff[39:24]});
      thr = {cfg.threshold[15], cfg.threshold};
      dif = {db[16], db} - {thr[16], thr};
      red = gt_ff ? prod_ff[32:16] : '0;
      g = $signed({4'd0, cfg.makeup}) - $signed({1'b0, red});
      gmag = g[17] ? 17'(-g) : g[16:0];
      q = prod_ff[30:8];
      g2 = neg_ff ? -$signed({1'b0, q}) : $signed({1'b0, q});
      sh = ip_ff - 8'sd6;
      nsh = -sh;
      case (state_ff)
         G_IDLE: begin
            if (start) begin
               peak_in = peak;
               state_in = G_ENV;
            end
         end
         G_ENV: begin
            up_in = tgt > env_ff;
            dlt = up_in ? tgt - env_ff : env_ff - tgt;
            coef = up_in ? cfg.att_coeff : cfg.rel_coeff;
            prod_in = 48'(dlt) * 48'(coef);
            state_in = G_ENVU;
         end
         G_ENVU: begin
            env_in = up_ff ? env_ff + prod_ff[47:16] : env_ff - prod_ff[47:16];
            norm_in = env_in;
            zero_in = env_in == '0;
            lz_in = '0;
            step_in = '0;
            state_in = G_NORM;
         end
         G_NORM: begin
            if ((norm_ff >> (6'd32 - amt)) == '0) begin
               norm_nxt = norm_ff << amt;
               lz_in = lz_ff + amt[4:0];
            end
            norm_in = norm_nxt;
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd4) begin
               x_in = norm_nxt[31:1];
               frac_in = '0;
               step_in = '0;
               state_in = G_LOG;
            end
         end
         G_LOG: begin
            x_in = t[31] ? t[31:1] : t[30:0];
            frac_in = {frac_ff[14:0], t[31]};
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd15) begin
               state_in = G_DB;
            end
         end
         G_DB: begin
            prod_in = 48'(aval) * 48'(bagc_pkg::DB_PER_OCT);
            state_in = G_SL;
         end
         G_SL: begin
            gt_in = dif > 18'sd0;
            prod_in = 48'(dif[16:0]) * 48'(cfg.slope);
            state_in = G_G;
         end
         G_G: begin
            neg_in = g[17];
            prod_in = 48'(gmag) * 48'(bagc_pkg::OCT_PER_DB);
            state_in = G_G2;
         end
         G_G2: begin
            ip_in = g2[23:16];
            f_in = g2[15:0];
            acc_in = bagc_pkg::ONE_Q30;
            step_in = '0;
            state_in = G_EXP;
         end
         G_EXP: begin
            if (f_ff[4'd15 - step_ff]) begin
               acc_in = eprod[60:30];
            end
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd15) begin
               state_in = G_SH;
            end
         end
         G_SH: begin
            if (!sh[7]) begin
               gain_in = bagc_pkg::GAIN_W'(acc_ff) << ((sh > 8'sd20) ? 5'd20 : sh[4:0]);
            end else begin
               gain_in = (nsh > 8'sd30) ? '0 : bagc_pkg::GAIN_W'(acc_ff) >> nsh[4:0];
            end
            done_in = 1'b1;
            state_in = G_IDLE;
         end
         default: begin
            state_in = G_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= G_IDLE;
         env_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         env_ff <= env_in;
         done_ff <= done_in;
      end
      peak_ff <= peak_in;
      up_ff <= up_in;
      prod_ff <= prod_in;
      norm_ff <= norm_in;
      lz_ff <= lz_in;
      step_ff <= step_in;
      x_ff <= x_in;
      frac_ff <= frac_in;
      zero_ff <= zero_in;
      gt_ff <= gt_in;
      neg_ff <= neg_in;
      ip_ff <= ip_in;
      f_ff <= f_in;
      acc_ff <= acc_in;
      gain_ff <= gain_in;
   end

   assign done = done_ff;
   assign gain = gain_ff;

endmodule

// ===== src/block_agc_compressor_core.sv =====
// a block ends on its last word or when BLOCK_LEN words are held; the gain is then
// computed, each stored sample is filtered and scaled, the output level is updated
// and result words are emitted; input takes one word per cycle while a block is
// collected and none while it is processed or emitted
// reset: synchronous, clears filter, envelopes, peak, fill and registers to defaults;
// sample and result memories are not cleared
module block_agc_compressor_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // sample_in
   input  logic        req_tlast,
   input  logic        req_tuser,   // read_error
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // sample_out, peak_level, level_env, zero pad
   output logic        rsp_tlast,
   output logic        rsp_tuser,   // clipped
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [22:0] csr_wdata
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_GST = 4'd1;
   localparam logic [3:0] S_GAIN = 4'd2;
   localparam logic [3:0] S_RD = 4'd3;
   localparam logic [3:0] S_HP = 4'd4;
   localparam logic [3:0] S_MUL = 4'd5;
   localparam logic [3:0] S_OUT = 4'd6;
   localparam logic [3:0] S_ENV1 = 4'd7;
   localparam logic [3:0] S_ENV2 = 4'd8;
   localparam logic [3:0] S_ERD = 4'd9;
   localparam logic [3:0] S_ELD = 4'd10;

   localparam int CW = bagc_pkg::CNT_W;
   localparam int AW = bagc_pkg::BLK_AW;
   localparam int RW = bagc_pkg::SMP_W + bagc_pkg::LVL_W;

   logic [15:0] hpf_ff, att_ff, rel_ff, thr_ff, slope_ff;
   logic [13:0] makeup_ff;
   logic [22:0] limit_ff;

   logic [3:0] state_ff, state_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] emit_ff, emit_in;
   logic [23:0] bam_ff, bam_in;
   logic err_ff, err_in;
   logic signed [bagc_pkg::HP_W-1:0] hp_ff, hp_in;
   logic signed [23:0] prev_ff, prev_in;
   logic [22:0] decay_ff, decay_in;
   logic [31:0] oenv_ff, oenv_in;
   logic [22:0] pmax_ff, pmax_in;
   logic clip_ff, clip_in;
   logic [bagc_pkg::HP_W-1:0] m_ff, m_in;
   logic hneg_ff, hneg_in;
   logic [38:0] dprod_ff, dprod_in;
   logic [bagc_pkg::MACC_W-1:0] macc_ff, macc_in;
   logic [1:0] mk_ff, mk_in;
   logic [47:0] oa_ff, oa_in;
   logic [35:0] ob_ff, ob_in;

   logic [23:0] st_mem [bagc_pkg::BLOCK_LEN];
   logic [RW-1:0] res_mem [bagc_pkg::BLOCK_LEN];
   logic [23:0] st_rd_ff;
   logic [RW-1:0] res_rd_ff;
   logic st_we, st_re, res_we, res_re;
   logic [RW-1:0] res_wdata;

   logic rsp_valid_ff, rsp_valid_in;
   logic [23:0] o_sample_ff;
   logic [22:0] o_peak_ff, o_level_ff;
   logic o_last_ff, o_clip_ff;
   logic load;

   logic accept;
   logic [23:0] absx;
   logic [CW-1:0] nfill;
   logic signed [24:0] diff;
   logic [bagc_pkg::HP_W-1:0] hpmag, fbm;
   logic [49:0] fprod;
   logic signed [35:0] fb, dsh, h36;
   logic signed [bagc_pkg::HP_W-1:0] h;
   logic [16:0] chunk;
   logic [bagc_pkg::GAIN_W-1:0] pp;
   logic clip_s;
   logic [22:0] ym, dnew;
   logic [23:0] y;
   logic [48:0] esum;
   logic pad;

   bagc_pkg::gain_cfg_type gcfg;
   logic gain_start, gain_done;
   logic [bagc_pkg::GAIN_W-1:0] gain;

   assign gcfg = '{att_coeff: att_ff, rel_coeff: rel_ff, threshold: thr_ff,
                   slope: slope_ff, makeup: makeup_ff};

   bagc_gain u_gain (
      .clock (clock),
      .reset (reset),
      .cfg   (gcfg),
      .start (gain_start),
      .peak  (bam_ff),
      .done  (gain_done),
      .gain  (gain)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         hpf_ff <= bagc_pkg::HPF_RST;
         att_ff <= bagc_pkg::ATTACK_RST;
         rel_ff <= bagc_pkg::RELEASE_RST;
         thr_ff <= bagc_pkg::THRESHOLD_RST;
         slope_ff <= bagc_pkg::SLOPE_RST;
         makeup_ff <= bagc_pkg::MAKEUP_RST;
         limit_ff <= bagc_pkg::LIMIT_RST;
      end else if (csr_we) begin
         case (csr_addr)
            bagc_pkg::CSR_HPF: hpf_ff <= csr_wdata[15:0];
            bagc_pkg::CSR_ATTACK: att_ff <= csr_wdata[15:0];
            bagc_pkg::CSR_RELEASE: rel_ff <= csr_wdata[15:0];
            bagc_pkg::CSR_THRESHOLD: thr_ff <= csr_wdata[15:0];
            bagc_pkg::CSR_SLOPE: slope_ff <= csr_wdata[15:0];
            bagc_pkg::CSR_MAKEUP: makeup_ff <= csr_wdata[13:0];
            bagc_pkg::CSR_LIMIT: limit_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign req_tready = state_ff == S_IDLE;
   assign accept = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      fill_in = fill_ff;
      n_in = n_ff;
      idx_in = idx_ff;
      emit_in = emit_ff;
      bam_in = bam_ff;
      err_in = err_ff;
      hp_in = hp_ff;
      prev_in = prev_ff;
      decay_in = decay_ff;
      oenv_in = oenv_ff;
      pmax_in = pmax_ff;
      clip_in = clip_ff;
      m_in = m_ff;
      hneg_in = hneg_ff;
      dprod_in = dprod_ff;
      macc_in = macc_ff;
      mk_in = mk_ff;
      oa_in = oa_ff;
      ob_in = ob_ff;
      st_we = 1'b0;
      st_re = 1'b0;
      res_we = 1'b0;
      res_re = 1'b0;
      gain_start = 1'b0;
      load = 1'b0;

      absx = req_tdata[23] ? 24'(-req_tdata) : req_tdata;
      nfill = fill_ff + CW'(1);

      diff = $signed({st_rd_ff[23], st_rd_ff}) - $signed({prev_ff[23], prev_ff});
      hpmag = hp_ff[bagc_pkg::HP_W-1] ? bagc_pkg::HP_W'(-hp_ff) : hp_ff;
      fprod = 50'(hpmag) * 50'(hpf_ff);
      fbm = fprod[49:16];
      fb = hp_ff[bagc_pkg::HP_W-1] ? -$signed({2'b00, fbm}) : $signed({2'b00, fbm});
      dsh = $signed({{11{diff[24]}}, diff}) <<< 8;
      h36 = fb + dsh;
      if (!h36[35] && h36[34:33] != 2'b00) begin
         h = {1'b0, {(bagc_pkg::HP_W-1){1'b1}}};
      end else if (h36[35] && h36[34:33] != 2'b11) begin
         h = {1'b1, {(bagc_pkg::HP_W-1){1'b0}}};
      end else begin
         h = h36[33:0];
      end

      chunk = 17'(gain >> (bagc_pkg::GCH * mk_ff));
      pp = bagc_pkg::GAIN_W'(m_ff) * bagc_pkg::GAIN_W'(chunk);

      clip_s = macc_ff > (bagc_pkg::MACC_W'(limit_ff) << 32);
      ym = clip_s ? limit_ff : macc_ff[54:32];
      y = hneg_ff ? 24'(-{1'b0, ym}) : {1'b0, ym};
      dnew = (ym > decay_ff) ? ym : dprod_ff[38:16];
      res_wdata = {dnew, y};

      esum = 49'(oa_ff) + (49'(ob_ff) << 8);
      pad = err_ff || (emit_ff >= n_ff);

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_tuser) begin
                  fill_in = '0;
                  bam_in = '0;
                  err_in = 1'b1;
                  emit_in = '0;
                  state_in = S_ERD;
               end else begin
                  st_we = 1'b1;
                  if (absx > bam_ff) begin
                     bam_in = absx;
                  end
                  if (req_tlast || nfill == CW'(bagc_pkg::BLOCK_LEN)) begin
                     n_in = nfill;
                     err_in = 1'b0;
                     state_in = S_GST;
                  end else begin
                     fill_in = nfill;
                  end
               end
            end
         end
         S_GST: begin
            gain_start = 1'b1;
            fill_in = '0;
            idx_in = '0;
            pmax_in = '0;
            clip_in = 1'b0;
            state_in = S_GAIN;
         end
         S_GAIN: begin
            bam_in = '0;
            if (gain_done) begin
               state_in = S_RD;
            end
         end
         S_RD: begin
            st_re = 1'b1;
            state_in = S_HP;
         end
         S_HP: begin
            hp_in = h;
            prev_in = st_rd_ff;
            hneg_in = h[bagc_pkg::HP_W-1];
            m_in = h[bagc_pkg::HP_W-1] ? bagc_pkg::HP_W'(-h) : h;
            dprod_in = 39'(decay_ff) * 39'(bagc_pkg::PEAK_DECAY);
            macc_in = '0;
            mk_in = '0;
            state_in = S_MUL;
         end
         S_MUL: begin
            macc_in = macc_ff + (bagc_pkg::MACC_W'(pp) << (bagc_pkg::GCH * mk_ff));
            mk_in = mk_ff + 2'd1;
            if (mk_ff == 2'(bagc_pkg::GNCH - 1)) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            res_we = 1'b1;
            decay_in = dnew;
            if (ym > pmax_ff) begin
               pmax_in = ym;
            end
            if (clip_s) begin
               clip_in = 1'b1;
            end
            idx_in = idx_ff + CW'(1);
            state_in = (idx_in == n_ff) ? S_ENV1 : S_RD;
         end
         S_ENV1: begin
            oa_in = 48'(oenv_ff) * 48'(bagc_pkg::OUT_W_OLD);
            ob_in = 36'(pmax_ff) * 36'(bagc_pkg::OUT_W_NEW);
            state_in = S_ENV2;
         end
         S_ENV2: begin
            oenv_in = esum[47:16];
            emit_in = '0;
            state_in = S_ERD;
         end
         S_ERD: begin
            res_re = 1'b1;
            state_in = S_ELD;
         end
         S_ELD: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load = 1'b1;
               emit_in = emit_ff + CW'(1);
               state_in = (emit_ff == CW'(bagc_pkg::BLOCK_LEN - 1)) ? S_IDLE : S_ERD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         st_mem[fill_ff[AW-1:0]] <= req_tdata;
      end
      if (st_re) begin
         st_rd_ff <= st_mem[idx_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (res_we) begin
         res_mem[idx_ff[AW-1:0]] <= res_wdata;
      end
      if (res_re) begin
         res_rd_ff <= res_mem[emit_ff[AW-1:0]];
      end
   end

   assign rsp_valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff <= '0;
         bam_ff <= '0;
         err_ff <= 1'b0;
         hp_ff <= '0;
         prev_ff <= '0;
         decay_ff <= '0;
         oenv_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         bam_ff <= bam_in;
         err_ff <= err_in;
         hp_ff <= hp_in;
         prev_ff <= prev_in;
         decay_ff <= decay_in;
         oenv_ff <= oenv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff <= n_in;
      idx_ff <= idx_in;
      emit_ff <= emit_in;
      pmax_ff <= pmax_in;
      clip_ff <= clip_in;
      m_ff <= m_in;
      hneg_ff <= hneg_in;
      dprod_ff <= dprod_in;
      macc_ff <= macc_in;
      mk_ff <= mk_in;
      oa_ff <= oa_in;
      ob_ff <= ob_in;
      if (load) begin
         o_sample_ff <= pad ? '0 : res_rd_ff[23:0];
         o_peak_ff <= pad ? decay_ff : res_rd_ff[RW-1:24];
         o_level_ff <= oenv_ff[30:8];
         o_clip_ff <= !err_ff && clip_ff;
         o_last_ff <= emit_ff == CW'(bagc_pkg::BLOCK_LEN - 1);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {2'b00, o_level_ff, o_peak_ff, o_sample_ff};
   assign rsp_tlast = o_last_ff;
   assign rsp_tuser = o_clip_ff;

`ifndef SYNTH
   a_gain_done_wait: assert property (@(posedge clock) disable iff (reset)
      gain_done |-> state_ff == S_GAIN)
      else $error("gain done outside gain wait");

   a_idx_in_block: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT |-> idx_ff < n_ff)
      else $error("processing index past block length");

   a_last_word: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ELD && load && emit_ff == CW'(bagc_pkg::BLOCK_LEN - 1))
      |=> state_ff == S_IDLE && rsp_tlast && rsp_tvalid)
      else $error("final word not marked or block not closed");
`endif

endmodule
